/* rtl/wpt_pkg.sv */
// Shared types and constants for the wheel pulse tachometer.
// No dependencies; every other file imports this package.
`default_nettype none

package wpt_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CIRC_W  = 16;
	localparam int unsigned RATE_W  = 24;
	localparam int unsigned DIST_W  = 42;
	localparam int unsigned K_W     = 23;
	localparam int unsigned PROD_W  = 56;
	localparam int unsigned DPROD_W = TIME_W + CIRC_W;
	localparam int unsigned IDX_W   = 2;

	// Quotient bits left after the overflow check on the top dividend bits.
	localparam int unsigned DIV_STEPS = RATE_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [K_W-1:0]    CENTI_RPM_PER_PULSE_MS = 23'd6000000;
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [TIME_W-1:0] LOCKOUT_RST  = 32'd500000;
	localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd1000;
	localparam logic [CIRC_W-1:0] CIRC_RST     = 16'd942;

	typedef enum logic [IDX_W-1:0] {
		REG_LOCKOUT  = 2'd0,
		REG_INTERVAL = 2'd1,
		REG_CIRC     = 2'd2
	} wpt_reg_t;

	typedef enum logic {
		OP_SENSOR = 1'b0,
		OP_REPORT = 1'b1
	} wpt_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MULT,
		ST_PREP,
		ST_DIV,
		ST_FINISH
	} wpt_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] lockout_us;
		logic [TIME_W-1:0] interval_ms;
		logic [CIRC_W-1:0] circumference_mm;
	} wpt_cfg_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic mult;
		logic prep;
		logic div_step;
		logic finish;
	} wpt_cmd_t;

	typedef struct packed {
		logic need_div;
	} wpt_sts_t;

	typedef struct packed {
		logic              pulse_counted;
		logic              report_valid;
		logic [RATE_W-1:0] rate_centi_rpm;
		logic [TIME_W-1:0] total_pulses;
		logic [DIST_W-1:0] distance_mm;
	} wpt_res_t;

endpackage

`default_nettype wire

/* rtl/wpt_if.sv */
// Valid/ready channel interfaces: sensor/tick items, results, register writes.
// Depends on wpt_pkg for field widths.
`default_nettype none

interface wpt_in_if
	import wpt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              op;
	logic              magnet_near;
	logic [TIME_W-1:0] time_us;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, op, magnet_near, time_us, time_ms, input ready);
	modport sink   (input valid, op, magnet_near, time_us, time_ms, output ready);
endinterface

interface wpt_out_if
	import wpt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              pulse_counted;
	logic              report_valid;
	logic [RATE_W-1:0] rate_centi_rpm;
	logic [TIME_W-1:0] total_pulses;
	logic [DIST_W-1:0] distance_mm;

	modport source (output valid, pulse_counted, report_valid, rate_centi_rpm,
		total_pulses, distance_mm, input ready);
	modport sink   (input valid, pulse_counted, report_valid, rate_centi_rpm,
		total_pulses, distance_mm, output ready);
endinterface

interface wpt_cfg_if
	import wpt_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [TIME_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/wheel_pulse_tachometer_unit.sv */
// Wheel pulse tachometer. An accepted item runs through the update, multiply and
// prepare states, plus the 24-step serial divider for a report with new pulses
// whose rate does not saturate, then registered for output. One item in flight;
// the next is accepted once the previous result sits in the output register.
// arst_n clears counters, timestamps and state; registers return to defaults.
// Depends on wpt_pkg, wpt_if, wpt_ctrl, wpt_dp.
`default_nettype none

module wheel_pulse_tachometer_unit
	import wpt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	wpt_in_if.sink    sample,
	wpt_out_if.source result,
	wpt_cfg_if.sink   cfg
);

	wpt_cfg_t cfg_q;
	wpt_cmd_t cmd;
	wpt_sts_t sts;
	wpt_res_t res;
	wpt_res_t out_q;
	logic     out_valid_q;
	logic     out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_us       <= LOCKOUT_RST;
			cfg_q.interval_ms      <= INTERVAL_RST;
			cfg_q.circumference_mm <= CIRC_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOCKOUT:  cfg_q.lockout_us       <= cfg.data;
				REG_INTERVAL: cfg_q.interval_ms      <= cfg.data;
				REG_CIRC:     cfg_q.circumference_mm <= cfg.data[CIRC_W-1:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign out_free = !out_valid_q || result.ready;

	wpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (sample.ready),
		.cmd      (cmd)
	);

	wpt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.in_op      (sample.op),
		.in_near    (sample.magnet_near),
		.in_time_us (sample.time_us),
		.in_time_ms (sample.time_ms),
		.sts        (sts),
		.res        (res)
	);

	// output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.pulse_counted  = out_q.pulse_counted;
	assign result.report_valid   = out_q.report_valid;
	assign result.rate_centi_rpm = out_q.rate_centi_rpm;
	assign result.total_pulses   = out_q.total_pulses;
	assign result.distance_mm    = out_q.distance_mm;

endmodule

`default_nettype wire

/* rtl/wpt_ctrl.sv */
// Controller FSM: sequences capture, update, multiply, prepare, divide, finish.
// Depends on wpt_pkg; drives the datapath through wpt_cmd_t.
`default_nettype none

module wpt_ctrl
	import wpt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     out_free,
	input  wire wpt_sts_t sts,
	output logic          in_ready,
	output wpt_cmd_t      cmd
);

	wpt_state_t state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic last_step;

	assign last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC:   state_nxt = ST_MULT;
			ST_MULT:   state_nxt = ST_PREP;
			ST_PREP: begin
				state_nxt = sts.need_div ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (last_step) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC:   cmd.exec     = 1'b1;
			ST_MULT:   cmd.mult     = 1'b1;
			ST_PREP:   cmd.prep     = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_FINISH: cmd.finish   = out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/wpt_dp.sv */
// Datapath: pulse/report state, rate and distance multipliers, serial divider.
// Depends on wpt_pkg; commanded by wpt_ctrl.
`default_nettype none

module wpt_dp
	import wpt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wpt_cmd_t          cmd,
	input  wire wpt_cfg_t          cfg,
	input  wire logic              in_op,
	input  wire logic              in_near,
	input  wire logic [TIME_W-1:0] in_time_us,
	input  wire logic [TIME_W-1:0] in_time_ms,
	output wpt_sts_t               sts,
	output wpt_res_t               res
);

	// tracked state
	logic [TIME_W-1:0] pulse_total_q;
	logic [TIME_W-1:0] last_pulse_time_q;
	logic              magnet_seen_q;
	logic [TIME_W-1:0] last_report_time_q;
	logic [TIME_W-1:0] last_report_total_q;

	// captured item and working registers
	logic              op_q;
	logic              near_q;
	logic [TIME_W-1:0] time_us_q;
	logic [TIME_W-1:0] time_ms_q;
	logic              counted_q;
	logic              valid_q;
	logic [TIME_W-1:0] delta_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [PROD_W-1:0] prod_q;
	logic [DPROD_W-1:0] dprod_q;
	logic [DIST_W-1:0] dist_q;
	logic [TIME_W-1:0] rem_q;
	logic [RATE_W-1:0] quo_q;
	logic              sat_q;

	logic [TIME_W-1:0] since_pulse;
	logic [TIME_W-1:0] elapsed_now;
	logic [TIME_W-1:0] delta_now;
	logic              pulse_ok;
	logic              due;
	logic [PROD_W-1:0] num;
	logic              sat_now;
	logic [TIME_W:0]   trial;
	logic [TIME_W:0]   shifted;

	assign since_pulse = time_us_q - last_pulse_time_q;
	assign pulse_ok    = (op_q == OP_SENSOR) && near_q && !magnet_seen_q
		&& (since_pulse > cfg.lockout_us);
	assign elapsed_now = time_ms_q - last_report_time_q;
	assign delta_now   = pulse_total_q - last_report_total_q;
	assign due         = (op_q == OP_REPORT) && (elapsed_now >= cfg.interval_ms);

	// rounding: add half the divisor before dividing
	assign num     = prod_q + PROD_W'(elapsed_q[TIME_W-1:1]);
	// a quotient of 2^24 or more shows up as top dividend bits >= divisor
	assign sat_now = (num[PROD_W-1:RATE_W] >= elapsed_q);
	assign sts.need_div = valid_q && !sat_now;

	assign shifted = {rem_q, quo_q[RATE_W-1]};
	assign trial   = shifted - {1'b0, elapsed_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_total_q       <= '0;
			last_pulse_time_q   <= '0;
			magnet_seen_q       <= 1'b0;
			last_report_time_q  <= '0;
			last_report_total_q <= '0;
		end else if (cmd.exec) begin
			if (pulse_ok) begin
				pulse_total_q     <= pulse_total_q + 1'b1;
				last_pulse_time_q <= time_us_q;
				magnet_seen_q     <= 1'b1;
			end else if ((op_q == OP_SENSOR) && !near_q) begin
				magnet_seen_q <= 1'b0;
			end
			if (due) begin
				last_report_time_q  <= time_ms_q;
				last_report_total_q <= pulse_total_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_op;
			near_q    <= in_near;
			time_us_q <= in_time_us;
			time_ms_q <= in_time_ms;
		end
		if (cmd.exec) begin
			counted_q <= pulse_ok;
			valid_q   <= due && (delta_now != '0);
			delta_q   <= delta_now;
			elapsed_q <= elapsed_now;
		end
		if (cmd.mult) begin
			prod_q  <= PROD_W'(delta_q) * PROD_W'(CENTI_RPM_PER_PULSE_MS);
			dprod_q <= DPROD_W'(pulse_total_q) * DPROD_W'(cfg.circumference_mm);
		end
		if (cmd.prep) begin
			rem_q <= num[PROD_W-1:RATE_W];
			quo_q <= num[RATE_W-1:0];
			sat_q <= sat_now;
			dist_q <= (dprod_q > DPROD_W'(DIST_MAX)) ? DIST_MAX : dprod_q[DIST_W-1:0];
		end
		// restoring division: quotient bits shift in where dividend bits leave
		if (cmd.div_step) begin
			if (!trial[TIME_W]) begin
				rem_q <= trial[TIME_W-1:0];
				quo_q <= {quo_q[RATE_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TIME_W-1:0];
				quo_q <= {quo_q[RATE_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		res.pulse_counted  = counted_q;
		res.report_valid   = valid_q;
		res.rate_centi_rpm = valid_q ? (sat_q ? RATE_MAX : quo_q) : '0;
		res.total_pulses   = pulse_total_q;
		res.distance_mm    = dist_q;
	end

endmodule

`default_nettype wire
